### sv/noac_pkg.sv
`timescale 1ns / 1ps
// Package for the nibble-opcode accumulator machine.
// Holds command and opcode codes, widths and the request/result structs; no dependencies.
package noac_pkg;

  localparam int MEM_WORDS = 16;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int DATA_W    = 8;
  localparam int NIB_W     = 4;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_RUN   = 2'd3
  } cmd_t;

  typedef enum logic [NIB_W-1:0] {
    OP_NOP   = 4'd0,
    OP_LOAD  = 4'd1,
    OP_ADD   = 4'd2,
    OP_SUB   = 4'd3,
    OP_STORE = 4'd4,
    OP_JUMP  = 4'd5,
    OP_LDI   = 4'd6,
    OP_JC    = 4'd7,
    OP_OUT   = 4'd8,
    OP_HALT  = 4'd9
  } op_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_val;
    logic              halted;
    logic [DATA_W-1:0] acc;
    logic [ADDR_W-1:0] pc;
  } result_t;

endpackage

### sv/noac_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module noac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/noac_seq.sv
`timescale 1ns / 1ps
// Instruction sequencer and architectural registers of the accumulator machine.
// Depends on noac_pkg; drives the ports of one noac_ram instance.
module noac_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            req_valid,
  input  noac_pkg::req_t                  req,
  output logic                            busy,
  output logic                            done,
  output noac_pkg::result_t               res,
  output logic                            ram_wr_en,
  output logic [noac_pkg::ADDR_W-1:0]     ram_wr_addr,
  output logic [noac_pkg::DATA_W-1:0]     ram_wr_data,
  output logic [noac_pkg::ADDR_W-1:0]     ram_rd_addr,
  input  logic [noac_pkg::DATA_W-1:0]     ram_rd_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_OPER
  } state_t;

  state_t                        state_r, state_nxt;
  logic [noac_pkg::ADDR_W-1:0]   pc_r, pc_nxt;
  logic [noac_pkg::DATA_W-1:0]   acc_r, acc_nxt;
  logic [noac_pkg::DATA_W-1:0]   outv_r, outv_nxt;
  logic                          halted_r, halted_nxt;
  logic [noac_pkg::NIB_W-1:0]    op_r, op_nxt;
  logic [noac_pkg::NIB_W-1:0]    arg;
  logic [noac_pkg::NIB_W-1:0]    op_f;

  assign op_f = ram_rd_data[noac_pkg::NIB_W-1:0];
  assign arg  = ram_rd_data[noac_pkg::DATA_W-1:noac_pkg::NIB_W];

  always_comb begin
    state_nxt   = state_r;
    pc_nxt      = pc_r;
    acc_nxt     = acc_r;
    outv_nxt    = outv_r;
    halted_nxt  = halted_r;
    op_nxt      = op_r;
    done        = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = req.addr;
    ram_wr_data = req.data;
    ram_rd_addr = pc_r;
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          done = 1'b1;
          case (req.cmd)
            noac_pkg::CMD_WRITE: begin
              ram_wr_en = 1'b1;
            end
            noac_pkg::CMD_START: begin
              halted_nxt = 1'b0;
            end
            noac_pkg::CMD_STOP: begin
              halted_nxt = 1'b1;
            end
            noac_pkg::CMD_RUN: begin
              if (!halted_r) begin
                done      = 1'b0;
                state_nxt = S_FETCH;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_FETCH: begin
        pc_nxt      = pc_r + 1'b1;
        op_nxt      = op_f;
        ram_rd_addr = arg[noac_pkg::ADDR_W-1:0];
        done        = 1'b1;
        state_nxt   = S_IDLE;
        case (op_f)
          noac_pkg::OP_LOAD, noac_pkg::OP_ADD, noac_pkg::OP_SUB: begin
            done      = 1'b0;
            state_nxt = S_OPER;
          end
          noac_pkg::OP_STORE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = arg[noac_pkg::ADDR_W-1:0];
            ram_wr_data = acc_r;
          end
          noac_pkg::OP_JUMP: begin
            pc_nxt = arg[noac_pkg::ADDR_W-1:0];
          end
          noac_pkg::OP_LDI: begin
            acc_nxt = {{(noac_pkg::DATA_W-noac_pkg::NIB_W){1'b0}}, arg};
          end
          noac_pkg::OP_OUT: begin
            outv_nxt = acc_r;
          end
          noac_pkg::OP_HALT: begin
            halted_nxt = 1'b1;
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      S_OPER: begin
        done      = 1'b1;
        state_nxt = S_IDLE;
        case (op_r)
          noac_pkg::OP_LOAD: begin
            acc_nxt = ram_rd_data;
          end
          noac_pkg::OP_ADD: begin
            acc_nxt = acc_r + ram_rd_data;
          end
          noac_pkg::OP_SUB: begin
            acc_nxt = acc_r - ram_rd_data;
          end
          default: begin
            acc_nxt = acc_r;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pc_r     <= '0;
      acc_r    <= '0;
      outv_r   <= '0;
      halted_r <= 1'b1;
      op_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      pc_r     <= pc_nxt;
      acc_r    <= acc_nxt;
      outv_r   <= outv_nxt;
      halted_r <= halted_nxt;
      op_r     <= op_nxt;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign res.out_val = outv_nxt;
  assign res.halted  = halted_nxt;
  assign res.acc     = acc_nxt;
  assign res.pc      = pc_nxt;

endmodule

### sv/nibble_opcode_accumulator_cpu.sv
`timescale 1ns / 1ps
// Top level of the nibble-opcode accumulator machine: handshake and result register.
// Depends on noac_pkg, noac_ram and noac_seq.
//
// An 8-bit accumulator machine with a 16-byte program/data memory. Each input
// transfer is one command (write a memory byte, start, stop, run one
// instruction) and yields exactly one result transfer carrying the output
// register, halted flag, accumulator and program counter after the command.
// Write, start, stop, and run while halted complete in the idle state. A run
// fetches the instruction, then executes it; load, add and sub go on to an
// operand state, since they need a second, dependent read of the
// single-read-port memory with its registered read data. The result sits in
// an output register, so the next command is taken in the same cycle as the
// previous result transfer; a stalled result holds off the input. The machine
// resets halted; memory content is undefined until written.
module nibble_opcode_accumulator_cpu (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_command,
  input  logic [noac_pkg::ADDR_W-1:0] in_load_address,
  input  logic [noac_pkg::DATA_W-1:0] in_load_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [noac_pkg::DATA_W-1:0] out_output_value,
  output logic                        out_halt_flag,
  output logic [noac_pkg::DATA_W-1:0] out_accumulator,
  output logic [noac_pkg::ADDR_W-1:0] out_program_counter
);

  noac_pkg::req_t                 req;
  noac_pkg::result_t              res;
  noac_pkg::result_t              res_r;
  logic                           busy;
  logic                           done;
  logic                           accept;
  logic                           out_valid_r;
  logic                           ram_wr_en;
  logic [noac_pkg::ADDR_W-1:0]    ram_wr_addr;
  logic [noac_pkg::DATA_W-1:0]    ram_wr_data;
  logic [noac_pkg::ADDR_W-1:0]    ram_rd_addr;
  logic [noac_pkg::DATA_W-1:0]    ram_rd_data;

  assign req.cmd  = noac_pkg::cmd_t'(in_command);
  assign req.addr = in_load_address;
  assign req.data = in_load_data;

  assign in_stall = busy | (out_valid_r & out_stall);
  assign accept   = in_valid & ~in_stall;

  noac_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (accept),
    .req         (req),
    .busy        (busy),
    .done        (done),
    .res         (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  noac_ram #(
    .WIDTH (noac_pkg::DATA_W),
    .DEPTH (noac_pkg::MEM_WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // hold the result until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_output_value    = res_r.out_val;
  assign out_halt_flag       = res_r.halted;
  assign out_accumulator     = res_r.acc;
  assign out_program_counter = res_r.pc;

endmodule
